// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/bhpq_pkg.sv -----
`timescale 1ns / 1ps

package bhpq_pkg;

    localparam int CAPACITY    = 256;
    localparam int ID_W        = 16;
    localparam int PRIO_W      = 16;
    localparam int WAIT_W      = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int REG_IDX_W   = CFG_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_HEAP_MODE = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_APPEND = 2'd2,
        KIND_BUILD  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic        [ID_W-1:0]   id;
        logic signed [PRIO_W-1:0] prio;
        logic        [WAIT_W-1:0] wtime;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_RD,
        S_RM_LD,
        S_BLD_RD,
        S_BLD_LD,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/binary_heap_priority_queue.sv -----
// Binary heap of process records (id, priority, wait time) with room for 256 entries.
// Input channel (i_in_valid / o_in_ready) takes one command beat: insert, remove top,
// append without ordering, or build the heap from the stored entries. Each command
// returns exactly one result beat on the output channel (o_out_valid / i_out_ready)
// with a status, the removed top record (zero unless a remove succeeds) and the count.
// The heap_mode register (APB, byte address 0) picks max order (0) or min order (1).
// Commands run one at a time on a single record compare unit and a memory with two
// registered read ports and one write port. Append and every rejected command go
// straight to the result; insert climbs level by level, reading and comparing each
// parent, remove reads the top and the last record and sifts the last one down from
// the top, and build sifts down each parent in turn. The block takes no new command
// until the result of the current one is loaded, and a stalled receiver holds the
// block after the following command finishes.
// Reset empties the heap and selects max order; stored records are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_heap_priority_queue (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic        [bhpq_pkg::KIND_W-1:0]       i_kind,
    input  logic        [bhpq_pkg::ID_W-1:0]         i_proc_id,
    input  logic signed [bhpq_pkg::PRIO_W-1:0]       i_priority_req,
    input  logic        [bhpq_pkg::WAIT_W-1:0]       i_wait_time,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic        [bhpq_pkg::STATUS_W-1:0]     o_status,
    output logic        [bhpq_pkg::ID_W-1:0]         o_top_id,
    output logic signed [bhpq_pkg::PRIO_W-1:0]       o_top_priority,
    output logic        [bhpq_pkg::WAIT_W-1:0]       o_top_wait_time,
    output logic        [bhpq_pkg::CNT_W-1:0]        o_entry_count,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic        [bhpq_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic        [bhpq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic        [bhpq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                     pready
);

    localparam int CNT_W  = bhpq_pkg::CNT_W;
    localparam int ADDR_W = bhpq_pkg::ADDR_W;

    bhpq_pkg::t_state  r_state, n_state;
    bhpq_pkg::t_rec    r_mem [bhpq_pkg::CAPACITY];
    bhpq_pkg::t_rec    r_rd_a, r_rd_b;
    bhpq_pkg::t_rec    r_cur, r_best, r_top;
    bhpq_pkg::t_status r_status;
    logic              r_mode;
    logic              r_build;
    logic [CNT_W-1:0]  r_cnt, r_pos, r_lim, r_best_pos;
    logic [CNT_W-2:0]  r_bi;

    logic              r_out_valid;
    bhpq_pkg::t_status r_o_status;
    bhpq_pkg::t_rec    r_o_top;
    logic [CNT_W-1:0]  r_o_cnt;

    bhpq_pkg::t_kind   kind;
    bhpq_pkg::t_rec    in_rec;
    logic              in_acc;
    logic              is_full;
    logic              cfg_wr;
    logic [CNT_W:0]    child_l, child_r;
    logic              l_ok, r_ok;
    logic [CNT_W-1:0]  parent;
    logic [ADDR_W-1:0] pos_addr;
    logic              take_r;
    logic [CNT_W-1:0]  fin_pos;
    logic              dn_stop;
    logic              build_more;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_addr_a, mem_addr_b;
    bhpq_pkg::t_rec    mem_wdata;
    bhpq_pkg::t_rec    cmp_a, cmp_b;
    logic              cmp_win;
    logic              out_load;

    assign kind         = bhpq_pkg::t_kind'(i_kind);
    assign in_rec.id    = i_proc_id;
    assign in_rec.prio  = i_priority_req;
    assign in_rec.wtime = i_wait_time;
    assign in_acc       = i_in_valid && o_in_ready;
    assign is_full      = (r_cnt == CNT_W'(bhpq_pkg::CAPACITY));
    assign cfg_wr       = psel && penable && pwrite && pready;

    assign child_l  = {r_pos, 1'b0};
    assign child_r  = child_l + 1'b1;
    assign l_ok     = (child_l <= {1'b0, r_lim});
    assign r_ok     = (child_r <= {1'b0, r_lim});
    assign parent   = r_pos >> 1;
    assign pos_addr = ADDR_W'(r_pos - 1'b1);

    // The shared compare unit: true when cmp_a must sit above cmp_b.
    assign cmp_win = r_mode ? (cmp_a.prio < cmp_b.prio) : (cmp_a.prio > cmp_b.prio);

    assign take_r     = r_ok && cmp_win;
    assign fin_pos    = take_r ? child_r[CNT_W-1:0] : r_best_pos;
    assign dn_stop    = (fin_pos == r_pos);
    assign build_more = r_build && (r_bi > 1'b1);

    assign pready          = 1'b1;
    assign prdata          = (paddr[bhpq_pkg::CFG_ADDR_W-1:2] == bhpq_pkg::REG_HEAP_MODE)
                             ? bhpq_pkg::APB_DATA_W'(r_mode) : '0;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_top_id        = r_o_top.id;
    assign o_top_priority  = r_o_top.prio;
    assign o_top_wait_time = r_o_top.wtime;
    assign o_entry_count   = r_o_cnt;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhpq_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (kind)
                        bhpq_pkg::KIND_INSERT:
                            n_state = is_full ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP_RD;
                        bhpq_pkg::KIND_APPEND:
                            n_state = bhpq_pkg::S_DONE;
                        bhpq_pkg::KIND_REMOVE:
                            n_state = (r_cnt == '0) ? bhpq_pkg::S_DONE : bhpq_pkg::S_RM_RD;
                        bhpq_pkg::KIND_BUILD:
                            n_state = (r_cnt < CNT_W'(2)) ? bhpq_pkg::S_DONE
                                                          : bhpq_pkg::S_BLD_RD;
                    endcase
                end
            end
            bhpq_pkg::S_UP_RD:
                n_state = (r_pos == CNT_W'(1)) ? bhpq_pkg::S_DONE : bhpq_pkg::S_UP_CMP;
            bhpq_pkg::S_UP_CMP:
                n_state = cmp_win ? bhpq_pkg::S_UP_RD : bhpq_pkg::S_DONE;
            bhpq_pkg::S_RM_RD:
                n_state = bhpq_pkg::S_RM_LD;
            bhpq_pkg::S_RM_LD:
                n_state = (r_cnt == CNT_W'(1)) ? bhpq_pkg::S_DONE : bhpq_pkg::S_DN_RD;
            bhpq_pkg::S_BLD_RD:
                n_state = bhpq_pkg::S_BLD_LD;
            bhpq_pkg::S_BLD_LD:
                n_state = bhpq_pkg::S_DN_RD;
            bhpq_pkg::S_DN_RD: begin
                if (l_ok) begin
                    n_state = bhpq_pkg::S_DN_L;
                end else begin
                    n_state = build_more ? bhpq_pkg::S_BLD_RD : bhpq_pkg::S_DONE;
                end
            end
            bhpq_pkg::S_DN_L:
                n_state = bhpq_pkg::S_DN_R;
            bhpq_pkg::S_DN_R: begin
                if (dn_stop) begin
                    n_state = build_more ? bhpq_pkg::S_BLD_RD : bhpq_pkg::S_DONE;
                end else begin
                    n_state = bhpq_pkg::S_DN_RD;
                end
            end
            bhpq_pkg::S_DONE:
                n_state = out_load ? bhpq_pkg::S_IDLE : bhpq_pkg::S_DONE;
            default:
                n_state = bhpq_pkg::S_IDLE;
        endcase
    end

    // Memory port and compare unit control. The record being sifted is held in
    // r_cur and written once it finds its slot; only displaced records move.
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = pos_addr;
        mem_wdata  = r_cur;
        mem_addr_a = pos_addr;
        mem_addr_b = pos_addr;
        cmp_a      = r_cur;
        cmp_b      = r_rd_a;
        unique case (r_state)
            bhpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc && (kind == bhpq_pkg::KIND_APPEND) && !is_full) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_cnt);
                    mem_wdata = in_rec;
                end
            end
            bhpq_pkg::S_UP_RD: begin
                if (r_pos == CNT_W'(1)) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re     = 1'b1;
                    mem_addr_a = ADDR_W'(parent - 1'b1);
                end
            end
            bhpq_pkg::S_UP_CMP: begin
                mem_we    = 1'b1;
                mem_wdata = cmp_win ? r_rd_a : r_cur;
            end
            bhpq_pkg::S_RM_RD: begin
                mem_re     = 1'b1;
                mem_addr_a = '0;
                mem_addr_b = ADDR_W'(r_cnt - 1'b1);
            end
            bhpq_pkg::S_BLD_RD: begin
                mem_re     = 1'b1;
                mem_addr_a = ADDR_W'(r_bi - 1'b1);
            end
            bhpq_pkg::S_DN_RD: begin
                if (l_ok) begin
                    mem_re     = 1'b1;
                    mem_addr_a = ADDR_W'(child_l - 1'b1);
                    mem_addr_b = ADDR_W'(child_l);
                end else begin
                    mem_we = 1'b1;
                end
            end
            bhpq_pkg::S_DN_L: begin
                cmp_a = r_rd_a;
                cmp_b = r_cur;
            end
            bhpq_pkg::S_DN_R: begin
                cmp_a     = r_rd_b;
                cmp_b     = r_best;
                mem_we    = 1'b1;
                mem_wdata = dn_stop ? r_cur : (take_r ? r_rd_b : r_best);
            end
            bhpq_pkg::S_DONE: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_a <= r_mem[mem_addr_a];
            r_rd_b <= r_mem[mem_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bhpq_pkg::S_IDLE;
            r_cnt       <= '0;
            r_mode      <= 1'b0;
            r_build     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr && (paddr[bhpq_pkg::CFG_ADDR_W-1:2] == bhpq_pkg::REG_HEAP_MODE)) begin
                r_mode <= pwdata[0];
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_o_status  <= r_status;
                r_o_top     <= r_top;
                r_o_cnt     <= r_cnt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                bhpq_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_top   <= '0;
                        r_cur   <= in_rec;
                        r_build <= (kind == bhpq_pkg::KIND_BUILD);
                        unique case (kind)
                            bhpq_pkg::KIND_INSERT, bhpq_pkg::KIND_APPEND: begin
                                if (is_full) begin
                                    r_status <= bhpq_pkg::STATUS_FULL;
                                end else begin
                                    r_status <= bhpq_pkg::STATUS_DONE;
                                    r_cnt    <= r_cnt + 1'b1;
                                    r_pos    <= r_cnt + 1'b1;
                                end
                            end
                            bhpq_pkg::KIND_REMOVE: begin
                                r_status <= (r_cnt == '0) ? bhpq_pkg::STATUS_EMPTY
                                                          : bhpq_pkg::STATUS_DONE;
                            end
                            bhpq_pkg::KIND_BUILD: begin
                                r_status <= bhpq_pkg::STATUS_DONE;
                                r_lim    <= r_cnt;
                                r_bi     <= r_cnt[CNT_W-1:1];
                            end
                        endcase
                    end
                end
                bhpq_pkg::S_UP_CMP: begin
                    if (cmp_win) begin
                        r_pos <= parent;
                    end
                end
                bhpq_pkg::S_RM_LD: begin
                    r_top <= r_rd_a;
                    r_cur <= r_rd_b;
                    r_cnt <= r_cnt - 1'b1;
                    r_lim <= r_cnt - 1'b1;
                    r_pos <= CNT_W'(1);
                end
                bhpq_pkg::S_BLD_LD: begin
                    r_cur <= r_rd_a;
                    r_pos <= {1'b0, r_bi};
                end
                bhpq_pkg::S_DN_RD: begin
                    if (!l_ok && build_more) begin
                        r_bi <= r_bi - 1'b1;
                    end
                end
                bhpq_pkg::S_DN_L: begin
                    // Left child first; the right child must then beat the winner kept here.
                    if (cmp_win) begin
                        r_best     <= r_rd_a;
                        r_best_pos <= child_l[CNT_W-1:0];
                    end else begin
                        r_best     <= r_cur;
                        r_best_pos <= r_pos;
                    end
                end
                bhpq_pkg::S_DN_R: begin
                    if (dn_stop) begin
                        if (build_more) begin
                            r_bi <= r_bi - 1'b1;
                        end
                    end else begin
                        r_pos <= fin_pos;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(bhpq_pkg::CAPACITY))
    `ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !in_acc && (r_state != bhpq_pkg::S_RM_LD), $stable(r_cnt))
    `ASSERT_NEXT(a_result_from_done, i_clk, i_rst_n, !r_out_valid && (r_state != bhpq_pkg::S_DONE), !r_out_valid)
    `ASSERT_IMPLY(a_down_bounds, i_clk, i_rst_n, r_state == bhpq_pkg::S_DN_RD, (r_pos >= CNT_W'(1)) && (r_pos <= r_lim) && (r_lim == r_cnt))
    `ASSERT_IMPLY(a_up_bounds, i_clk, i_rst_n, r_state == bhpq_pkg::S_UP_RD, (r_pos >= CNT_W'(1)) && (r_pos <= r_cnt))

endmodule

// ----- tb/binary_heap_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module binary_heap_priority_queue_tb;

    localparam int CAPACITY   = bhpq_pkg::CAPACITY;
    localparam int CNT_W      = bhpq_pkg::CNT_W;
    localparam int KIND_W     = bhpq_pkg::KIND_W;
    localparam int STATUS_W   = bhpq_pkg::STATUS_W;
    localparam int ID_W       = bhpq_pkg::ID_W;
    localparam int PRIO_W     = bhpq_pkg::PRIO_W;
    localparam int WAIT_W     = bhpq_pkg::WAIT_W;
    localparam int CFG_ADDR_W = bhpq_pkg::CFG_ADDR_W;
    localparam int APB_DATA_W = bhpq_pkg::APB_DATA_W;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SORT_PULLS  = 120;
    localparam int MIX_PHASES  = 3;
    localparam int MIX_LEN     = 16;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_MOSTLY   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct {
        bhpq_pkg::t_status status;
        bhpq_pkg::t_rec    top;
        logic [CNT_W-1:0]  count;
    } t_heap_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [KIND_W-1:0]        i_kind;
    logic [ID_W-1:0]          i_proc_id;
    logic signed [PRIO_W-1:0] i_priority_req;
    logic [WAIT_W-1:0]        i_wait_time;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [STATUS_W-1:0]      o_status;
    logic [ID_W-1:0]          o_top_id;
    logic signed [PRIO_W-1:0] o_top_priority;
    logic [WAIT_W-1:0]        o_top_wait_time;
    logic [CNT_W-1:0]         o_entry_count;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    // Shadow copy of the heap, updated at the beat on which each command is accepted.
    bhpq_pkg::t_rec mirror_heap [1:CAPACITY];
    int             mirror_count = 0;
    logic           mirror_mode  = 1'b0;
    t_heap_result   pending_results[$];

    int   err_count   = 0;
    int   rx_hold_req = 0;
    int   burst_left  = 0;
    logic pace_on     = 1'b1;

    binary_heap_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .i_wait_time    (i_wait_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_top_id       (o_top_id),
        .o_top_priority (o_top_priority),
        .o_top_wait_time(o_top_wait_time),
        .o_entry_count  (o_entry_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic ranks_above(input bhpq_pkg::t_rec a, input bhpq_pkg::t_rec b);
        if (mirror_mode)
            return $signed(a.prio) < $signed(b.prio);
        return $signed(a.prio) > $signed(b.prio);
    endfunction

    function automatic void mirror_swap(input int a, input int b);
        bhpq_pkg::t_rec tmp;
        tmp            = mirror_heap[a];
        mirror_heap[a] = mirror_heap[b];
        mirror_heap[b] = tmp;
    endfunction

    function automatic void mirror_sift_up(input int start);
        int pos;
        pos = start;
        while (pos > 1 && ranks_above(mirror_heap[pos], mirror_heap[pos / 2])) begin
            mirror_swap(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    // Left child is tested first; ties never move a record.
    function automatic void mirror_sift_down(input int start, input int n);
        int pos;
        int best;
        pos = start;
        forever begin
            best = pos;
            if (2 * pos <= n && ranks_above(mirror_heap[2 * pos], mirror_heap[best]))
                best = 2 * pos;
            if (2 * pos + 1 <= n && ranks_above(mirror_heap[2 * pos + 1], mirror_heap[best]))
                best = 2 * pos + 1;
            if (best == pos)
                break;
            mirror_swap(pos, best);
            pos = best;
        end
    endfunction

    function automatic t_heap_result predict_heap_op(input bhpq_pkg::t_kind kind,
                                                     input bhpq_pkg::t_rec rec);
        t_heap_result res;
        res.status = bhpq_pkg::STATUS_DONE;
        res.top    = '0;
        case (kind)
            bhpq_pkg::KIND_INSERT, bhpq_pkg::KIND_APPEND: begin
                if (mirror_count >= CAPACITY) begin
                    res.status = bhpq_pkg::STATUS_FULL;
                end else begin
                    mirror_count++;
                    mirror_heap[mirror_count] = rec;
                    if (kind == bhpq_pkg::KIND_INSERT)
                        mirror_sift_up(mirror_count);
                end
            end
            bhpq_pkg::KIND_REMOVE: begin
                if (mirror_count == 0) begin
                    res.status = bhpq_pkg::STATUS_EMPTY;
                end else begin
                    res.top        = mirror_heap[1];
                    mirror_heap[1] = mirror_heap[mirror_count];
                    mirror_count--;
                    mirror_sift_down(1, mirror_count);
                end
            end
            default: begin
                for (int i = mirror_count / 2; i >= 1; i--)
                    mirror_sift_down(i, mirror_count);
            end
        endcase
        res.count = CNT_W'(mirror_count);
        return res;
    endfunction

    // ---------------------------------------------------------------- result checking

    task automatic compare_field(input string what, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_heap_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t ns: result beat mismatch, expected none, got status %0d",
                         $time, o_status);
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, o_status);
                compare_field("top_id", want.top.id, o_top_id);
                compare_field("top_priority", want.top.prio, o_top_priority);
                compare_field("top_wait_time", want.top.wtime, o_top_wait_time);
                compare_field("entry_count", want.count, o_entry_count);
            end
        end
    end

    // The receiver changes its stall style every so often and honors hold requests.
    initial begin : result_stall
        int hold_left;
        int hold_seen;
        int style;
        int style_left;
        hold_left   = 0;
        hold_seen   = 0;
        style       = RX_ALWAYS;
        style_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != hold_seen) begin
                hold_seen = rx_hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (style_left == 0) begin
                style      = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (style)
                    RX_ALWAYS: i_out_ready <= 1'b1;
                    RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_out_ready <= (style_left % 5 < 2);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    function automatic bhpq_pkg::t_rec make_rec(input int id, input int prio, input int wtime);
        bhpq_pkg::t_rec r;
        r.id    = ID_W'(id);
        r.prio  = PRIO_W'(prio);
        r.wtime = WAIT_W'(wtime);
        return r;
    endfunction

    // A quarter of the keys come from a small pool so that ties are common.
    function automatic bhpq_pkg::t_rec random_rec();
        bhpq_pkg::t_rec r;
        r.id    = ID_W'($urandom);
        r.wtime = WAIT_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0:       r.prio = 16'sh8000;
                1:       r.prio = -16'sd1;
                2:       r.prio = 16'sd0;
                3:       r.prio = 16'sd1;
                default: r.prio = 16'sh7fff;
            endcase
        end else begin
            r.prio = PRIO_W'($urandom);
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is accepted.
    task automatic send_heap_cmd(input bhpq_pkg::t_kind kind, input bhpq_pkg::t_rec rec);
        if (pace_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_proc_id      <= rec.id;
        i_priority_req <= rec.prio;
        i_wait_time    <= rec.wtime;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_heap_op(kind, rec));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_heap_mode(input logic mode);
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * int'(bhpq_pkg::REG_HEAP_MODE));
        pwdata  <= APB_DATA_W'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        mirror_mode = mode;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_max();
        set_heap_mode(1'b0);
        send_heap_cmd(bhpq_pkg::KIND_REMOVE, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_BUILD, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(16'hffff, 32767, 16'hffff));
        send_heap_cmd(bhpq_pkg::KIND_BUILD, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_REMOVE, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_REMOVE, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(0, -32768, 0));
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(1, 0, 1));
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(2, 32767, 2));
        send_heap_cmd(bhpq_pkg::KIND_APPEND, make_rec(3, -1, 3));
        send_heap_cmd(bhpq_pkg::KIND_APPEND, make_rec(4, 1, 4));
        // Equal key to an entry already present: strict compare keeps it below.
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(5, 0, 5));
        send_heap_cmd(bhpq_pkg::KIND_BUILD, random_rec());
        repeat (7) send_heap_cmd(bhpq_pkg::KIND_REMOVE, random_rec());
    endtask

    task automatic test_directed_min();
        set_heap_mode(1'b1);
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(10, 32767, 100));
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(11, -32768, 200));
        send_heap_cmd(bhpq_pkg::KIND_INSERT, make_rec(12, 5, 300));
        send_heap_cmd(bhpq_pkg::KIND_APPEND, make_rec(13, -32768, 400));
        repeat (4) send_heap_cmd(bhpq_pkg::KIND_REMOVE, random_rec());
    endtask

    // Fills the heap while the receiver is held off, so the input side backs up,
    // then hits the full case, heapifies the whole store and pulls a run of tops.
    task automatic test_fill_and_sort();
        set_heap_mode(1'b0);
        pace_on = 1'b0;
        rx_hold_req <= rx_hold_req + 1;
        for (int i = 0; i < CAPACITY; i++)
            send_heap_cmd(bhpq_pkg::KIND_APPEND, random_rec());
        wait_results_drained();
        pace_on = 1'b1;
        send_heap_cmd(bhpq_pkg::KIND_INSERT, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_APPEND, random_rec());
        send_heap_cmd(bhpq_pkg::KIND_BUILD, random_rec());
        for (int i = 0; i < SORT_PULLS; i++)
            send_heap_cmd(bhpq_pkg::KIND_REMOVE, random_rec());
    endtask

    // Each phase drifts the fill level toward its own target, mostly small.
    task automatic test_random_mix();
        int              target;
        int              r;
        int              add_pct;
        int              flip;
        bhpq_pkg::t_kind kind;
        flip = $urandom_range(0, 1);
        for (int ph = 0; ph < MIX_PHASES; ph++) begin
            set_heap_mode(1'((ph + flip) % 2));
            if ($urandom_range(0, 2) == 0)
                target = $urandom_range(9, 80);
            else
                target = $urandom_range(0, 8);
            if ($urandom_range(0, 1))
                send_heap_cmd(bhpq_pkg::KIND_BUILD, random_rec());
            for (int n = 0; n < MIX_LEN; n++) begin
                r       = $urandom_range(0, 99);
                add_pct = (mirror_count < target) ? 75 : 30;
                if (r < 5)
                    kind = bhpq_pkg::KIND_BUILD;
                else if (r < 5 + add_pct)
                    kind = ($urandom_range(0, 3) != 0) ? bhpq_pkg::KIND_INSERT
                                                       : bhpq_pkg::KIND_APPEND;
                else
                    kind = bhpq_pkg::KIND_REMOVE;
                send_heap_cmd(kind, random_rec());
            end
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_kind         <= bhpq_pkg::KIND_INSERT;
        i_proc_id      <= '0;
        i_priority_req <= '0;
        i_wait_time    <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_max();
        test_directed_min();
        test_fill_and_sort();
        test_random_mix();

        i_in_valid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && pending_results.size() != 0; c++)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            err_count++;
            $display("%0t ns: result count mismatch, expected 0 outstanding, got %0d",
                     $time, pending_results.size());
        end
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bhpq_pkg.sv
rtl/core/binary_heap_priority_queue.sv
tb/binary_heap_priority_queue_tb.sv
